// File: src/sexpr_token_scanner_unit_assert.svh
// Assertion macros shared by the token scanner modules.
`ifndef SEXPR_TOKEN_SCANNER_UNIT_ASSERT_SVH
`define SEXPR_TOKEN_SCANNER_UNIT_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define SXTOK_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define SXTOK_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// File: src/sxtok_pkg.sv
// Shared types, constants and byte classification for the token scanner.
package sxtok_pkg;

    // Width of the integer token value.
    localparam int INT_BITS = 31;

    // Token kind codes.
    localparam logic [2:0] KIND_OPEN  = 3'd0;
    localparam logic [2:0] KIND_CLOSE = 3'd1;
    localparam logic [2:0] KIND_IDENT = 3'd2;
    localparam logic [2:0] KIND_INT   = 3'd3;
    localparam logic [2:0] KIND_EOS   = 3'd4;
    localparam logic [2:0] KIND_ERR   = 3'd5;

    // Error codes.
    localparam logic ERR_UNEXPECTED = 1'b0;
    localparam logic ERR_RANGE      = 1'b1;

    // Special characters.
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Job queue depth between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] source_byte;
        logic       end_of_source;
    } t_in;

    typedef struct packed {
        logic [2:0]          token_kind;
        logic [7:0]          ident_char;
        logic                ident_final;
        logic [INT_BITS-1:0] int_value;
        logic                error_code;
        logic                last_of_run;
    } t_out;

    // One input byte's results: one or two tokens.
    typedef struct packed {
        t_out res0;
        t_out res1;
        logic two;
    } t_job;

    typedef enum logic [2:0] {
        CLS_SPACE,
        CLS_OPEN,
        CLS_CLOSE,
        CLS_IDENT,
        CLS_DIGIT,
        CLS_OTHER
    } t_byte_class;

    // Builds a token with the last-of-run flag clear.
    function automatic t_out make_token(input logic [2:0] kind, input logic [7:0] ch,
                                        input logic fin, input logic [INT_BITS-1:0] val,
                                        input logic err);
        t_out t;
        t.token_kind  = kind;
        t.ident_char  = ch;
        t.ident_final = fin;
        t.int_value   = val;
        t.error_code  = err;
        t.last_of_run = 1'b0;
        return t;
    endfunction

    // Sorts a source byte into its lexical class.
    function automatic t_byte_class classify(input logic [7:0] b);
        t_byte_class c;
        priority if (b == CH_OPEN) begin
            c = CLS_OPEN;
        end else if (b == CH_CLOSE) begin
            c = CLS_CLOSE;
        end else if (b == 8'h20 || (b >= 8'h09 && b <= 8'h0D)) begin
            c = CLS_SPACE;
        end else if (b >= CH_ZERO && b <= CH_NINE) begin
            c = CLS_DIGIT;
        end else if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) begin
            c = CLS_IDENT;
        end else if (b == 8'h21 || b == 8'h24 || b == 8'h25 || b == 8'h26 ||
                     b == 8'h2A || b == 8'h2B || b == 8'h2D || b == 8'h2E ||
                     b == 8'h2F || b == 8'h3A || b == 8'h3C || b == 8'h3D ||
                     b == 8'h3E || b == 8'h3F || b == 8'h40 || b == 8'h5E ||
                     b == 8'h5F || b == 8'h7E) begin
            c = CLS_IDENT;
        end else begin
            c = CLS_OTHER;
        end
        return c;
    endfunction

endpackage

// File: src/sxtok_front.sv
// Front end: classifies each source byte, tracks the scan state and builds token jobs.
module sxtok_front import sxtok_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_in  i_item,
    input  logic i_q_full,
    output logic o_ready,
    output logic o_job_push,
    output t_job o_job
);

    `include "sexpr_token_scanner_unit_assert.svh"

    localparam int PW = INT_BITS + 4;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_INT,
        MODE_DEAD
    } t_mode;

    t_mode               r_mode, n_mode;
    logic [7:0]          r_held, n_held;
    logic [INT_BITS-1:0] r_acc, n_acc;
    logic                r_ovf, n_ovf;

    logic accept;
    logic flush_v, tail_v, live, start;
    t_out flush_r, tail_r;
    t_byte_class cls;
    logic [3:0]    digit;
    logic [PW-1:0] acc_w, prod;
    logic          eos;
    logic [7:0]    b;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign b       = i_item.source_byte;
    assign eos     = i_item.end_of_source;
    assign cls     = classify(b);
    assign digit   = b[3:0];

    // Next decimal value: acc * 10 + digit, wide enough to see an overflow.
    assign acc_w = PW'(r_acc);
    assign prod  = (acc_w << 3) + (acc_w << 1) + PW'(digit);

    // Scan step: a flushed or continued token first, then a token from the new byte.
    always_comb begin
        n_mode  = r_mode;
        n_held  = r_held;
        n_acc   = r_acc;
        n_ovf   = r_ovf;
        flush_v = 1'b0;
        tail_v  = 1'b0;
        flush_r = '0;
        tail_r  = '0;
        live    = 1'b1;
        start   = 1'b0;

        unique case (r_mode)
            MODE_DEAD: begin
                live = 1'b0;
            end
            MODE_IDENT: begin
                flush_v = 1'b1;
                if (!eos && (cls == CLS_IDENT || cls == CLS_DIGIT)) begin
                    flush_r = make_token(KIND_IDENT, r_held, 1'b0, '0, 1'b0);
                    n_held  = b;
                end else begin
                    flush_r = make_token(KIND_IDENT, r_held, 1'b1, '0, 1'b0);
                    n_held  = '0;
                    n_mode  = MODE_IDLE;
                    start   = !eos;
                end
            end
            MODE_INT: begin
                if (!eos && cls == CLS_DIGIT) begin
                    if (!r_ovf) begin
                        if (prod[PW-1:INT_BITS] != '0) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_acc = prod[INT_BITS-1:0];
                        end
                    end
                end else if (r_ovf) begin
                    flush_v = 1'b1;
                    flush_r = make_token(KIND_ERR, '0, 1'b0, '0, ERR_RANGE);
                    n_mode  = MODE_DEAD;
                    live    = 1'b0;
                end else begin
                    flush_v = 1'b1;
                    flush_r = make_token(KIND_INT, '0, 1'b0, r_acc, 1'b0);
                    n_mode  = MODE_IDLE;
                    n_acc   = '0;
                    start   = !eos;
                end
            end
            default: begin
                start = !eos;
            end
        endcase

        // A byte seen with no token pending.
        if (start) begin
            unique case (cls)
                CLS_OPEN: begin
                    tail_v = 1'b1;
                    tail_r = make_token(KIND_OPEN, '0, 1'b0, '0, 1'b0);
                end
                CLS_CLOSE: begin
                    tail_v = 1'b1;
                    tail_r = make_token(KIND_CLOSE, '0, 1'b0, '0, 1'b0);
                end
                CLS_SPACE: begin
                end
                CLS_IDENT: begin
                    n_mode = MODE_IDENT;
                    n_held = b;
                end
                CLS_DIGIT: begin
                    n_mode = MODE_INT;
                    n_acc  = INT_BITS'(digit);
                    n_ovf  = 1'b0;
                end
                default: begin
                    tail_v = 1'b1;
                    tail_r = make_token(KIND_ERR, '0, 1'b0, '0, ERR_UNEXPECTED);
                    n_mode = MODE_DEAD;
                end
            endcase
        end

        // End of source closes the stream.
        if (eos && live) begin
            tail_v = 1'b1;
            tail_r = make_token(KIND_EOS, '0, 1'b0, '0, 1'b0);
            n_mode = MODE_IDLE;
        end
    end

    // Pack the one or two tokens into a job, flagging the last one.
    always_comb begin
        if (flush_v) begin
            o_job.res0             = flush_r;
            o_job.res0.last_of_run = !tail_v;
            o_job.res1             = tail_r;
            o_job.res1.last_of_run = 1'b1;
            o_job.two              = tail_v;
        end else begin
            o_job.res0             = tail_r;
            o_job.res0.last_of_run = 1'b1;
            o_job.res1             = tail_r;
            o_job.res1.last_of_run = 1'b1;
            o_job.two              = 1'b0;
        end
    end

    assign o_job_push = accept && (flush_v || tail_v);

    // Scan state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_held <= '0;
            r_acc  <= '0;
            r_ovf  <= 1'b0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_held <= n_held;
            r_acc  <= n_acc;
            r_ovf  <= n_ovf;
        end
    end

    `SXTOK_ASSERT_ALWAYS(a_dead_silent, i_clk, i_rst_n, !(r_mode == MODE_DEAD && o_job_push), "dead scanner produced a token")
    `SXTOK_ASSERT_NEXT(a_eos_idle, i_clk, i_rst_n, accept && eos && r_mode != MODE_DEAD && !(r_mode == MODE_INT && r_ovf), r_mode == MODE_IDLE, "end of source did not return to idle")

endmodule

// File: src/sxtok_queue.sv
// Short job queue that decouples the front end from the token output stage.
module sxtok_queue import sxtok_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_head
);

    `include "sexpr_token_scanner_unit_assert.svh"

    t_job                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr, r_rd;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic                   do_push, do_pop;

    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `SXTOK_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue count beyond depth")
    `SXTOK_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, do_push && !do_pop, r_count == $past(r_count) + 1'b1, "queue count did not grow on push")

endmodule

// File: src/sxtok_back.sv
// Back end: takes jobs from the queue and hands out their tokens one per request.
module sxtok_back import sxtok_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_empty,
    input  t_job i_head,
    output logic o_q_pop,
    output logic o_empty,
    input  logic i_pop,
    output t_out o_token
);

    `include "sexpr_token_scanner_unit_assert.svh"

    t_job r_job;
    logic r_valid;
    logic r_idx;
    logic advance, done, load;

    // Step to the second token of a job, or finish the job.
    assign advance = r_valid && i_pop && !r_idx && r_job.two;
    assign done    = r_valid && i_pop && !advance;
    assign load    = (!r_valid || done) && !i_q_empty;
    assign o_q_pop = load;
    assign o_empty = !r_valid;
    assign o_token = r_idx ? r_job.res1 : r_job.res0;

    // Output control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 1'b0;
        end else if (advance) begin
            r_idx <= 1'b1;
        end else if (!r_valid || done) begin
            r_valid <= !i_q_empty;
            r_idx   <= 1'b0;
        end
    end

    // Job register.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_head;
        end
    end

    `SXTOK_ASSERT_ALWAYS(a_second_exists, i_clk, i_rst_n, !(r_valid && r_idx) || r_job.two, "second token shown for a one-token job")

endmodule

// File: src/sexpr_token_scanner_unit.sv
// S-expression token scanner: top level joining front end, job queue and output stage.
//
// Usage:
//   Source bytes enter on i_item with push/full: a request is taken at a clock edge
//   where push is high and full is low. Set end_of_source on the last request of a
//   text to flush a pending token and get an end-of-stream token.
//   Tokens leave on o_token with empty/pop: the oldest token is shown while empty is
//   low and is taken at an edge where pop is high. last_of_run marks the final token
//   caused by one input byte; one byte causes zero, one or two tokens.
// Path: the job for an accepted request is written to the queue at the edge that
//   accepts the request and moves into the output register once that register is free.
// Throughput: one byte per cycle while full is low; the output stage hands out one token
//   per cycle while pop is high, so a byte that causes two tokens needs two pops.
// Stalls: a four-entry job queue sits between the front end and the output stage;
//   full is high while that queue holds four jobs. With pop held low, the output
//   register and the queue take five token-producing bytes before full rises.
// Reset (i_rst_n low, synchronous) returns the scanner to idle and drops all
//   pending tokens. After an error the scanner ignores input until reset.
module sexpr_token_scanner_unit import sxtok_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    output logic full,
    input  t_in  i_item,
    output logic empty,
    input  logic pop,
    output t_out o_token
);

    logic front_ready;
    logic job_push;
    t_job job;
    logic q_full, q_empty, q_pop;
    t_job q_head;

    assign full = !front_ready;

    // Byte classification and scan state.
    sxtok_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (push),
        .i_item     (i_item),
        .i_q_full   (q_full),
        .o_ready    (front_ready),
        .o_job_push (job_push),
        .o_job      (job)
    );

    // Decoupling queue.
    sxtok_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // Token output stage.
    sxtok_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_head    (q_head),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_token   (o_token)
    );

endmodule
